@@ hw/rtl/lrc_pkg.sv @@
// lrc_pkg: shared types, palette and helpers for the label rank colouriser.
// No dependencies.
package lrc_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    localparam int unsigned CHUNK_BITS = 16;

    localparam logic CMD_SURVEY   = 1'b0;
    localparam logic CMD_COLORIZE = 1'b1;

    localparam logic [7:0] RED_MUL   = 8'd73;
    localparam logic [7:0] GREEN_MUL = 8'd151;
    localparam logic [7:0] BLUE_MUL  = 8'd211;

    localparam t_rgb PALETTE [16] = '{
        '{8'd0,   8'd0,   8'd0},
        '{8'd255, 8'd0,   8'd0},
        '{8'd0,   8'd255, 8'd0},
        '{8'd0,   8'd0,   8'd255},
        '{8'd255, 8'd255, 8'd0},
        '{8'd255, 8'd0,   8'd255},
        '{8'd0,   8'd255, 8'd255},
        '{8'd255, 8'd128, 8'd0},
        '{8'd128, 8'd0,   8'd255},
        '{8'd255, 8'd192, 8'd203},
        '{8'd128, 8'd128, 8'd128},
        '{8'd255, 8'd165, 8'd0},
        '{8'd0,   8'd128, 8'd0},
        '{8'd128, 8'd0,   8'd0},
        '{8'd0,   8'd0,   8'd128},
        '{8'd128, 8'd128, 8'd0}
    };

    function automatic logic [4:0] popcount16(input logic [15:0] bits);
        logic [4:0] cnt;
        cnt = 5'd0;
        for (int i = 0; i < 16; i++) begin
            cnt = cnt + 5'(bits[i]);
        end
        return cnt;
    endfunction

endpackage

@@ hw/rtl/label_rank_colorizer.sv @@
// label_rank_colorizer: presence map, chunked rank counter and colour lookup.
// Depends on lrc_pkg.
//
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+--------------------------
// command   | i_cmd, i_frame_start, i_label           | start & !busy
// colour    | o_red, o_green, o_blue                  | o_valid, one-cycle strobe
//
// Survey transaction: busy stays low, no result.
// Colourise transaction: busy in ST_COUNT then ST_DONE (label present) or
// ST_DONE only (absent); the rank counter adds one 16-bit map chunk per cycle.
// Strobe comes in the cycle busy falls. Synchronous active-low reset clears
// the presence map at once. The receiver cannot stall; results are not held.
module label_rank_colorizer #(
    parameter int unsigned LABEL_COUNT = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_cmd,
    input  logic       i_frame_start,
    input  logic [7:0] i_label,
    output logic       o_valid,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);

    localparam int unsigned NCHUNK  = (LABEL_COUNT + lrc_pkg::CHUNK_BITS - 1)
                                      / lrc_pkg::CHUNK_BITS;
    localparam int unsigned MAP_W   = NCHUNK * lrc_pkg::CHUNK_BITS;
    localparam int unsigned CHUNK_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_COUNT = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [MAP_W-1:0] r_map,   n_map;
    logic [7:0]       r_label, n_label;
    logic [3:0]       r_chunk, n_chunk;
    logic [7:0]       r_rank,  n_rank;
    logic             r_hit,   n_hit;
    logic             r_valid;
    lrc_pkg::t_rgb    r_rgb,   w_rgb;

    logic             w_accept;
    logic             w_in_range;
    logic             w_present;
    logic [15:0]      w_chunk_bits;
    logic [15:0]      w_mask;
    logic             w_last;

    assign w_accept   = start && !busy;
    assign w_in_range = (32'(i_label) < LABEL_COUNT);
    assign w_present  = w_in_range && r_map[i_label];

    assign w_chunk_bits = r_map[r_chunk[CHUNK_W-1:0] * lrc_pkg::CHUNK_BITS +: 16];
    assign w_last       = (r_chunk == r_label[7:4]);
    assign w_mask       = w_last ? ((16'd1 << r_label[3:0]) - 16'd1) : 16'hFFFF;

    always_comb begin
        if (!r_hit) begin
            w_rgb = '0;
        end else if (r_rank < 8'd16) begin
            w_rgb = lrc_pkg::PALETTE[r_rank[3:0]];
        end else begin
            w_rgb.red   = r_rank * lrc_pkg::RED_MUL;
            w_rgb.green = r_rank * lrc_pkg::GREEN_MUL;
            w_rgb.blue  = r_rank * lrc_pkg::BLUE_MUL;
        end
    end

    always_comb begin
        n_state = r_state;
        n_map   = r_map;
        n_label = r_label;
        n_chunk = r_chunk;
        n_rank  = r_rank;
        n_hit   = r_hit;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_cmd == lrc_pkg::CMD_SURVEY) begin
                        if (i_frame_start) begin
                            n_map = '0;
                        end
                        if (w_in_range) begin
                            n_map[i_label] = 1'b1;
                        end
                    end else begin
                        n_label = i_label;
                        n_chunk = 4'd0;
                        n_rank  = 8'd0;
                        n_hit   = w_present;
                        n_state = w_present ? ST_COUNT : ST_DONE;
                    end
                end
            end
            ST_COUNT: begin
                n_rank  = r_rank + 8'(lrc_pkg::popcount16(w_chunk_bits & w_mask));
                n_chunk = r_chunk + 4'd1;
                if (w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_map   <= '0;
            r_hit   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_map   <= n_map;
            r_hit   <= n_hit;
            r_valid <= (r_state == ST_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_label <= n_label;
        r_chunk <= n_chunk;
        r_rank  <= n_rank;
        if (r_state == ST_DONE) begin
            r_rgb <= w_rgb;
        end
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_red   = r_rgb.red;
    assign o_green = r_rgb.green;
    assign o_blue  = r_rgb.blue;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_chunk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COUNT) |-> (r_chunk <= r_label[7:4]))
        else $error("rank counter ran past the label chunk");

    a_survey_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_cmd == lrc_pkg::CMD_SURVEY) |=> !busy)
        else $error("survey transaction made the block busy");

    a_absent_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !r_hit) |=> (o_red == 8'd0 && o_green == 8'd0
                                            && o_blue == 8'd0))
        else $error("absent label did not give black");

endmodule
